[sv/asrr_pkg.sv]
// ----------------------------------------------------------------------------
// asrr_pkg
// shared types and constants of the audio sample ring with resync
// ----------------------------------------------------------------------------
package asrr_pkg;

   // ring size in samples, a power of two
   localparam int RING_DEPTH = 4096;
   localparam int ADDR_W     = $clog2(RING_DEPTH);

   localparam int POS_W    = 64;
   localparam int GEN_W    = 32;
   localparam int SAMPLE_W = 16;
   localparam int FACTOR_W = 4;
   localparam int FUNC_W   = 2;

   localparam logic [POS_W-1:0]    DEPTH_POS     = POS_W'(RING_DEPTH);
   localparam logic [FACTOR_W-1:0] MAX_EXPANSION = FACTOR_W'(12);
   localparam logic [FACTOR_W-1:0] FACTOR_RESET  = FACTOR_W'(1);

   // request kinds
   localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BEGIN   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd3;

   // result handed from the sequencer to the output register
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       frame_valid;
   } asrr_result_type;

endpackage

[sv/audio_sample_ring_with_resync_top.sv]
// ----------------------------------------------------------------------------
// audio_sample_ring_with_resync_top
// audio sample ring with upsampling writer and resyncing reader
// ----------------------------------------------------------------------------
// usage:
//   req channel: tuser is the request kind (write, begin stream, read,
//   restart), tdata the signed 16-bit sample used by writes.
//   rsp channel: one response per read request, tdata the Q1.15 sample,
//   tuser[0] set when a stored sample was consumed (sample is 0 otherwise).
//   csr channel: writes the expansion factor (copies per written sample);
//   always ready, write it only while the block is idle.
// sequence:
//   write request: one ram write per copy of the sample;
//   a factor of 0 or above 12 drops the write.
//   begin stream and restart: handled in the idle state on acceptance.
//   read request: the sequencer steps through resync, position compare,
//   clamp, registered ram read and delivery to the response register; the
//   ram read is skipped when nothing is available. the next request is
//   taken once delivery completes.
// reset: positions, generations and the response valid clear, the factor
//   returns to 1; the sample ram is not cleared.
// stall: a held response waits in the output register while the next
//   requests are accepted; a further read stops at delivery until the
//   register frees up.
// ----------------------------------------------------------------------------
module audio_sample_ring_with_resync_top (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic signed [asrr_pkg::SAMPLE_W-1:0] req_tdata,  // [15:0] sample_in
   input  logic [asrr_pkg::FUNC_W-1:0]      req_tuser,      // [1:0] func
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic signed [asrr_pkg::SAMPLE_W-1:0] rsp_tdata,  // [15:0] sample_out
   output logic [0:0]                       rsp_tuser,      // [0] frame_valid
   // configuration write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [asrr_pkg::FACTOR_W-1:0]    csr_data        // expansion_factor
);
   import asrr_pkg::*;

   logic [FACTOR_W-1:0]        factor_ff,  factor_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   logic signed [SAMPLE_W-1:0] rsp_smp_ff;
   logic                       rsp_fv_ff;
   logic                       out_ready;
   asrr_result_type            result;

   // expansion factor register
   assign csr_ready = 1'b1;
   assign factor_in = (csr_valid && csr_ready) ? csr_data : factor_ff;

   // output register frees when empty or when taken this cycle
   assign out_ready  = !rsp_vld_ff || rsp_tready;
   assign rsp_vld_in = result.valid ? 1'b1 : (rsp_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff  <= FACTOR_RESET;
         rsp_vld_ff <= 1'b0;
      end else begin
         factor_ff  <= factor_in;
         rsp_vld_ff <= out_ready ? rsp_vld_in : rsp_vld_ff;
      end
   end

   // payload, loaded as the sequencer hands over a result
   always_ff @(posedge clock) begin
      if (result.valid && out_ready) begin
         rsp_smp_ff <= result.sample;
         rsp_fv_ff  <= result.frame_valid;
      end
   end

   asrr_ring_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_func   (req_tuser),
      .req_sample (req_tdata),
      .factor     (factor_ff),
      .out_ready  (out_ready),
      .result     (result)
   );

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = rsp_smp_ff;
   assign rsp_tuser[0] = rsp_fv_ff;

endmodule

[sv/asrr_sample_ram.sv]
// ----------------------------------------------------------------------------
// asrr_sample_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module asrr_sample_ram #(
   parameter int DEPTH  = 4096,
   parameter int DATA_W = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/asrr_ring_ctrl.sv]
// ----------------------------------------------------------------------------
// asrr_ring_ctrl
// request sequencer: write and read positions, generations, sample ram
// ----------------------------------------------------------------------------
module asrr_ring_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [asrr_pkg::FUNC_W-1:0]      req_func,
   input  logic signed [asrr_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [asrr_pkg::FACTOR_W-1:0]    factor,
   input  logic                             out_ready,
   output asrr_pkg::asrr_result_type        result
);
   import asrr_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_WRITE   = 3'd1;
   localparam logic [2:0] ST_SYNC    = 3'd2;
   localparam logic [2:0] ST_DIFF    = 3'd3;
   localparam logic [2:0] ST_CLAMP   = 3'd4;
   localparam logic [2:0] ST_RAM     = 3'd5;
   localparam logic [2:0] ST_DELIVER = 3'd6;

   logic [2:0]          state_ff,  state_in;
   logic [POS_W-1:0]    wp_ff,     wp_in;
   logic [POS_W-1:0]    ss_ff,     ss_in;
   logic [GEN_W-1:0]    sgen_ff,   sgen_in;
   logic [POS_W-1:0]    rp_ff,     rp_in;
   logic [GEN_W-1:0]    rgen_ff,   rgen_in;
   logic [FACTOR_W-1:0] copies_ff, copies_in;
   logic                avail_ff,  avail_in;
   logic [POS_W:0]      diff_ff,   diff_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;

   logic                ram_we;
   logic                ram_re;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic                accept;
   logic                factor_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign factor_ok = (factor != '0) && (factor <= MAX_EXPANSION);

   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      ss_in     = ss_ff;
      sgen_in   = sgen_ff;
      rp_in     = rp_ff;
      rgen_in   = rgen_ff;
      copies_in = copies_ff;
      avail_in  = avail_ff;
      diff_in   = diff_ff;
      sample_in = sample_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_WRITE: begin
                     if (factor_ok) begin
                        sample_in = req_sample;
                        copies_in = factor;
                        state_in  = ST_WRITE;
                     end
                  end
                  FUNC_BEGIN: begin
                     ss_in   = wp_ff;
                     sgen_in = sgen_ff + 1'b1;
                  end
                  FUNC_READ: begin
                     state_in = ST_SYNC;
                  end
                  default: begin
                     wp_in   = '0;
                     ss_in   = '0;
                     sgen_in = sgen_ff + 1'b1;
                  end
               endcase
            end
         end
         ST_WRITE: begin
            ram_we    = 1'b1;
            wp_in     = wp_ff + 1'b1;
            copies_in = copies_ff - 1'b1;
            if (copies_ff == FACTOR_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_SYNC: begin
            // jump to the stream start after a begin or restart
            if (sgen_ff != rgen_ff) begin
               rgen_in = sgen_ff;
               rp_in   = ss_ff;
            end
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in  = {1'b0, wp_ff} - {1'b0, rp_ff};
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (diff_ff[POS_W]) begin
               // reader ahead of writer
               rp_in    = wp_ff;
               avail_in = 1'b0;
               state_in = ST_DELIVER;
            end else if (diff_ff[POS_W-1:0] > DEPTH_POS) begin
               // overrun: skip to the oldest retained sample
               rp_in    = wp_ff - DEPTH_POS;
               state_in = ST_RAM;
            end else if (diff_ff[POS_W-1:0] == '0) begin
               avail_in = 1'b0;
               state_in = ST_DELIVER;
            end else begin
               state_in = ST_RAM;
            end
         end
         ST_RAM: begin
            ram_re   = 1'b1;
            rp_in    = rp_ff + 1'b1;
            avail_in = 1'b1;
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wp_ff     <= '0;
         ss_ff     <= '0;
         sgen_ff   <= '0;
         rp_ff     <= '0;
         rgen_ff   <= '0;
         copies_ff <= '0;
         avail_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wp_ff     <= wp_in;
         ss_ff     <= ss_in;
         sgen_ff   <= sgen_in;
         rp_ff     <= rp_in;
         rgen_ff   <= rgen_in;
         copies_ff <= copies_in;
         avail_ff  <= avail_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff   <= diff_in;
      sample_ff <= sample_in;
   end

   asrr_sample_ram #(
      .DEPTH  (RING_DEPTH),
      .DATA_W (SAMPLE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff[ADDR_W-1:0]),
      .wr_data (sample_ff),
      .rd_en   (ram_re),
      .rd_addr (rp_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      result.valid       = (state_ff == ST_DELIVER);
      result.frame_valid = avail_ff;
      result.sample      = avail_ff ? $signed(ram_rdata) : '0;
   end

endmodule

[sv/asrr_checker.sv]
// ----------------------------------------------------------------------------
// asrr_checker
// port-level checks of the audio sample ring, bound to the top level
// ----------------------------------------------------------------------------
module asrr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic signed [asrr_pkg::SAMPLE_W-1:0] rsp_tdata,
   input logic [0:0]                       rsp_tuser
);

   // a held response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // an empty read returns a zero sample
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("nonzero sample on empty read");

   // no response straight out of reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // a response needs a read request accepted after reset
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3))
      else $error("response too soon after reset");

endmodule

bind audio_sample_ring_with_resync_top asrr_checker u_asrr_checker (.*);

[tb/audio_sample_ring_with_resync_top_tb.sv]
// ----------------------------------------------------------------------------
// audio_sample_ring_with_resync_top_tb
// self-checking bench for the audio sample ring with resync
// ----------------------------------------------------------------------------
// a shadow copy of the ring follows every accepted request and queues the
// frame that each read request should return; responses are checked field by
// field against the oldest queued frame. a short directed run covers the
// extreme samples, every request kind, empty reads and resync after begin
// stream and restart. random phases then sweep the expansion factor,
// including the out-of-range values that drop writes, and build up a backlog
// larger than the ring to force the reader overrun clamp. both sides stall
// in random bursts except in the last phase.
// ----------------------------------------------------------------------------
module audio_sample_ring_with_resync_top_tb;
   import asrr_pkg::*;

   localparam int CLK_HALF   = 10;
   localparam int QUIET_WAIT = 20;    // lets the longest write request finish
   localparam int STALL_MAX  = 5000;  // cycles with no handshake at all

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic signed [SAMPLE_W-1:0] req_tdata;
   logic [FUNC_W-1:0]          req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic signed [SAMPLE_W-1:0] rsp_tdata;
   logic [0:0]                 rsp_tuser;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [FACTOR_W-1:0]        csr_data;

   // random stalls on both channels while set
   bit stalls_on = 1'b1;
   int quiet_cycles;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                frame_valid;
   } frame_type;

   // shadow of the ring: positions, generations and store, plus the
   // frames that outstanding read requests are owed
   class ring_tracker;
      logic [SAMPLE_W-1:0] store [RING_DEPTH];
      logic [POS_W-1:0]    wr_pos;
      logic [POS_W-1:0]    rd_pos;
      logic [POS_W-1:0]    start_pos;
      logic [GEN_W-1:0]    stream_gen;
      logic [GEN_W-1:0]    reader_gen;
      logic [FACTOR_W-1:0] factor;
      frame_type           owed_frames[$];
      int                  errors;
      int                  frames_full;
      int                  frames_empty;
      int                  overruns;
      int                  resyncs;
      int                  dropped_writes;

      function new();
         foreach (store[i]) store[i] = '0;
         wr_pos         = '0;
         rd_pos         = '0;
         start_pos      = '0;
         stream_gen     = '0;
         reader_gen     = '0;
         factor         = FACTOR_RESET;
         errors         = 0;
         frames_full    = 0;
         frames_empty   = 0;
         overruns       = 0;
         resyncs        = 0;
         dropped_writes = 0;
      endfunction

      function void set_factor(logic [FACTOR_W-1:0] value);
         factor = value;
      endfunction

      function int pending();
         return owed_frames.size();
      endfunction

      // advance the shadow by one accepted request
      function void note_request(logic [FUNC_W-1:0] func, logic [SAMPLE_W-1:0] sample);
         frame_type fr;
         int        k;
         case (func)
            FUNC_WRITE: begin
               if (factor == '0 || factor > MAX_EXPANSION) begin
                  dropped_writes++;
               end else begin
                  for (k = 0; k < int'(factor); k++) begin
                     store[wr_pos[ADDR_W-1:0]] = sample;
                     wr_pos++;
                  end
               end
            end
            FUNC_BEGIN: begin
               start_pos = wr_pos;
               stream_gen++;
            end
            FUNC_READ: begin
               if (stream_gen != reader_gen) begin
                  reader_gen = stream_gen;
                  rd_pos     = start_pos;
                  resyncs++;
               end
               // reader ahead of writer falls back, a lapped reader skips to
               // the oldest sample still held
               if (wr_pos < rd_pos) begin
                  rd_pos = wr_pos;
               end else if (wr_pos - rd_pos > DEPTH_POS) begin
                  rd_pos = wr_pos - DEPTH_POS;
                  overruns++;
               end
               if (wr_pos > rd_pos) begin
                  fr.sample      = store[rd_pos[ADDR_W-1:0]];
                  fr.frame_valid = 1'b1;
                  rd_pos++;
                  frames_full++;
               end else begin
                  fr.sample      = '0;
                  fr.frame_valid = 1'b0;
                  frames_empty++;
               end
               owed_frames.push_back(fr);
            end
            default: begin
               wr_pos    = '0;
               start_pos = '0;
               stream_gen++;
            end
         endcase
      endfunction

      function void check_frame(logic [SAMPLE_W-1:0] sample, logic frame_valid);
         frame_type fr;
         if (owed_frames.size() == 0) begin
            $error("response with no read request outstanding: sample_out %0d",
                   $signed(sample));
            errors++;
            return;
         end
         fr = owed_frames.pop_front();
         if (sample !== fr.sample) begin
            $error("sample_out: expected %0d, actual %0d",
                   $signed(fr.sample), $signed(sample));
            errors++;
         end
         if (frame_valid !== fr.frame_valid) begin
            $error("frame_valid: expected %0b, actual %0b", fr.frame_valid, frame_valid);
            errors++;
         end
      endfunction
   endclass

   ring_tracker shadow = new();

   audio_sample_ring_with_resync_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #CLK_HALF;
      clock = 1'b0;
      #CLK_HALF;
   end

   // response checking and the stall watchdog, both on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            shadow.check_frame(rsp_tdata, rsp_tuser[0]);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_MAX) begin
            $display("timeout: no handshake for %0d cycles", STALL_MAX);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // receiver: ready most of the time, dropped for random bursts while stalls are on
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stalls_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // one request; entered and left at a falling edge, valid stays high
   task automatic send_request(input logic [FUNC_W-1:0] func,
                               input logic [SAMPLE_W-1:0] sample);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      shadow.note_request(func, sample);
      @(negedge clock);
   endtask

   // wait for every owed response, then let a long write finish
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (QUIET_WAIT) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_factor(input logic [FACTOR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      shadow.set_factor(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random requests under one expansion factor; the mix decides whether
   // the backlog grows past the ring or the reader keeps up
   task automatic run_phase(input logic [FACTOR_W-1:0] value, input int count,
                            input int read_pct, input int begin_pct,
                            input int restart_pct);
      int               n;
      int               pick;
      logic [FUNC_W-1:0] func;
      wait_quiet();
      write_factor(value);
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < read_pct)
            func = FUNC_READ;
         else if (pick < read_pct + begin_pct)
            func = FUNC_BEGIN;
         else if (pick < read_pct + begin_pct + restart_pct)
            func = FUNC_RESTART;
         else
            func = FUNC_WRITE;
         send_request(func, SAMPLE_W'($urandom));
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FUNC_WRITE;
      csr_valid  = 1'b0;
      csr_data   = FACTOR_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part under the reset factor of one
      send_request(FUNC_READ,    16'h0000);  // empty ring after reset
      send_request(FUNC_WRITE,   16'h7fff);  // largest positive
      send_request(FUNC_WRITE,   16'h8000);  // most negative
      send_request(FUNC_WRITE,   16'h0000);
      send_request(FUNC_WRITE,   16'hffff);
      send_request(FUNC_WRITE,   16'h0001);
      send_request(FUNC_READ,    16'hffff);
      send_request(FUNC_READ,    16'h0000);
      send_request(FUNC_READ,    16'h1234);
      send_request(FUNC_BEGIN,   16'hffff);  // reader jumps to the write head
      send_request(FUNC_READ,    16'h0000);  // resync leaves nothing to read
      send_request(FUNC_WRITE,   16'h1234);
      send_request(FUNC_READ,    16'h0000);
      send_request(FUNC_READ,    16'h0000);  // drained again
      send_request(FUNC_RESTART, 16'hffff);  // writer reopened at zero
      send_request(FUNC_WRITE,   16'ha5a5);
      send_request(FUNC_READ,    16'h0000);
      send_request(FUNC_READ,    16'h0000);
      send_request(FUNC_BEGIN,   16'h0000);
      send_request(FUNC_BEGIN,   16'h0000);  // second bump, still one resync
      send_request(FUNC_READ,    16'h0000);
      send_request(FUNC_WRITE,   16'h5a5a);
      send_request(FUNC_READ,    16'h0000);

      run_phase(4'd12, 200, 30, 8, 3);
      run_phase(4'd0,  120, 40, 10, 5);   // writes dropped
      run_phase(4'd12, 450, 2, 0, 0);     // backlog well past the ring depth
      run_phase(4'd12, 150, 90, 2, 0);    // lapped reader skips ahead
      run_phase(4'd5,  250, 45, 8, 4);
      run_phase(4'd13, 100, 40, 10, 5);   // just above the limit, dropped
      run_phase(4'd15, 80,  40, 10, 5);
      run_phase(4'd3,  250, 45, 6, 3);
      run_phase(4'd1,  250, 50, 6, 3);
      wait_quiet();
      stalls_on = 1'b0;                   // last stretch at full rate
      run_phase(4'd7,  200, 40, 6, 3);
      wait_quiet();

      $display("covered %0d full and %0d empty reads, %0d resyncs, %0d overrun skips",
               shadow.frames_full, shadow.frames_empty, shadow.resyncs, shadow.overruns);
      $display("dropped %0d writes at out-of-range factors, factors 0 to 15 mixed",
               shadow.dropped_writes);
      if (shadow.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
